// ===== sv/buddy_allocator_macros.svh =====
// Assertion macros used by the buddy allocator sequencer
`ifndef BUDDY_ALLOCATOR_MACROS_SVH
`define BUDDY_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define BAL_IMPLIES(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BAL_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/bal_pkg.sv =====
// Shared types and constants of the buddy allocator
package bal_pkg;

  localparam logic [31:0] BASE_RESET   = 32'h0080_0000;
  localparam logic [3:0]  HEADER_BYTES = 4'd8;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef enum logic [1:0] {
    L_ADD    = 2'd0,
    L_UNLINK = 2'd1,
    L_TAKE   = 2'd2,
    L_CLEAR  = 2'd3
  } list_op_t;

  typedef struct packed {
    logic     start;
    list_op_t op;
  } list_cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
  } list_rsp_t;

  typedef enum logic {
    T_READ = 1'b0,
    T_FLIP = 1'b1
  } tree_op_t;

  typedef struct packed {
    logic     start;
    tree_op_t op;
  } tree_cmd_t;

  typedef struct packed {
    logic done;
    logic value;
    logic ready;
  } tree_rsp_t;

endpackage

// ===== sv/bal_list.sv =====
// Free lists: link memories, class tails and list add/unlink/take/clear
module bal_list #(
  parameter int SLOT_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bal_pkg::list_cmd_t                 cmd,
  input  logic [$clog2(SLOT_BITS+1)-1:0]     cls,
  input  logic [SLOT_BITS-1:0]               slot,
  output bal_pkg::list_rsp_t                 rsp,
  output logic [SLOT_BITS-1:0]               slot_out
);
  import bal_pkg::*;

  localparam int SL     = SLOT_BITS;
  localparam int LW     = SL + 1;
  localparam int NSLOT  = 1 << SL;
  localparam int NCLASS = SL + 1;
  localparam int CW     = $clog2(NCLASS);

  typedef enum logic [2:0] {
    LS_IDLE = 3'b001,
    LS_ADD2 = 3'b010,
    LS_UNL  = 3'b100
  } lst_state_t;

  lst_state_t state, state_next;

  logic [LW-1:0] prev_mem [NSLOT];
  logic [LW-1:0] next_mem [NSLOT];
  logic [LW-1:0] head_tail [NCLASS];

  logic [LW-1:0] prev_rd, next_rd;
  logic [LW-1:0] tail_in, tail_q;
  logic [SL-1:0] slot_q;
  logic [CW-1:0] cls_q;
  logic [SL-1:0] rd_addr;
  logic          prev_we, next_we;
  logic [SL-1:0] prev_wa, next_wa;
  logic [LW-1:0] prev_wd, next_wd;
  logic          finish, ok_val;
  logic          q_head;
  logic          done_q, ok_q;

  assign tail_in = head_tail[cls];
  assign rd_addr = (cmd.op == L_TAKE) ? tail_in[SL-1:0] : slot;
  assign q_head  = next_rd[SL] && (next_rd[SL-1:0] < SL'(NCLASS));

  always_comb begin
    state_next = state;
    prev_we = 1'b0;
    next_we = 1'b0;
    prev_wa = slot;
    next_wa = slot;
    prev_wd = tail_in;
    next_wd = {1'b1, SL'(cls)};
    finish  = 1'b0;
    ok_val  = 1'b0;
    unique case (state)
      LS_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.op)
            L_ADD: begin
              prev_we    = 1'b1;
              next_we    = 1'b1;
              state_next = LS_ADD2;
            end
            L_UNLINK: state_next = LS_UNL;
            L_TAKE: begin
              if (tail_in[SL]) begin
                finish = 1'b1;
              end else begin
                state_next = LS_UNL;
              end
            end
            L_CLEAR: finish = 1'b1;
            default: finish = 1'b1;
          endcase
        end
      end
      LS_ADD2: begin
        next_we    = !tail_q[SL];
        next_wa    = tail_q[SL-1:0];
        next_wd    = {1'b0, slot_q};
        finish     = 1'b1;
        state_next = LS_IDLE;
      end
      LS_UNL: begin
        next_we    = !prev_rd[SL];
        next_wa    = prev_rd[SL-1:0];
        next_wd    = next_rd;
        prev_we    = !next_rd[SL];
        prev_wa    = next_rd[SL-1:0];
        prev_wd    = prev_rd;
        finish     = 1'b1;
        ok_val     = 1'b1;
        state_next = LS_IDLE;
      end
      default: state_next = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= LS_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= finish;
    end
  end

  always_ff @(posedge clk) begin
    ok_q <= ok_val;
    if (state == LS_IDLE) begin
      tail_q <= tail_in;
      slot_q <= rd_addr;
      cls_q  <= cls;
    end
  end

  assign rsp      = '{done: done_q, ok: ok_q};
  assign slot_out = slot_q;

  always_ff @(posedge clk) begin
    if (state == LS_IDLE && cmd.start && cmd.op == L_CLEAR) begin
      head_tail[cls] <= {1'b1, SL'(cls)};
    end else if (state == LS_ADD2) begin
      head_tail[cls_q] <= {1'b0, slot_q};
    end else if (state == LS_UNL && q_head) begin
      head_tail[next_rd[CW-1:0]] <= prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[rd_addr];
  end

endmodule

// ===== sv/bal_tree.sv =====
// Split-bit memory with post-reset clearing sweep and read/flip access
module bal_tree #(
  parameter int SLOT_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bal_pkg::tree_cmd_t   cmd,
  input  logic [SLOT_BITS:0]   node,
  output bal_pkg::tree_rsp_t   rsp
);
  import bal_pkg::*;

  localparam int SL    = SLOT_BITS;
  localparam int NW    = SL + 1;
  localparam int NSLOT = 1 << SL;

  typedef enum logic [2:0] {
    TS_CLEAR = 3'b001,
    TS_IDLE  = 3'b010,
    TS_RD    = 3'b100
  } tree_state_t;

  tree_state_t state, state_next;

  logic          split_mem [NSLOT];
  logic          mem_rd;
  logic [SL-1:0] clr_cnt;
  logic [NW-1:0] node_m1;
  logic [SL-1:0] idx, idx_q;
  tree_op_t      op_q;
  logic          we, wd, finish, val;
  logic [SL-1:0] wa;
  logic          done_q, value_q;

  assign node_m1 = node - NW'(1);
  assign idx     = node_m1[SL:1];

  always_comb begin
    state_next = state;
    we     = 1'b0;
    wa     = idx_q;
    wd     = !mem_rd;
    finish = 1'b0;
    val    = 1'b0;
    unique case (state)
      TS_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
        wd = 1'b0;
        if (&clr_cnt) begin
          state_next = TS_IDLE;
        end
      end
      TS_IDLE: begin
        if (cmd.start) begin
          if (node == '0) begin
            finish = 1'b1;
          end else begin
            state_next = TS_RD;
          end
        end
      end
      TS_RD: begin
        we         = (op_q == T_FLIP);
        val        = (op_q == T_FLIP) ? !mem_rd : mem_rd;
        finish     = 1'b1;
        state_next = TS_IDLE;
      end
      default: state_next = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= TS_CLEAR;
      clr_cnt <= '0;
      done_q  <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= finish;
      if (state == TS_CLEAR) begin
        clr_cnt <= clr_cnt + SL'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    value_q <= val;
    if (state == TS_IDLE) begin
      idx_q <= idx;
      op_q  <= cmd.op;
    end
  end

  assign rsp = '{done: done_q, value: value_q, ready: (state != TS_CLEAR)};

  always_ff @(posedge clk) begin
    if (we) begin
      split_mem[wa] <= wd;
    end
    mem_rd <= split_mem[idx];
  end

endmodule

// ===== sv/bal_ctrl.sv =====
// Allocate/free sequencer driving the free-list and split-bit units
`include "buddy_allocator_macros.svh"
module bal_ctrl #(
  parameter int HEAP_LOG2      = 16,
  parameter int MIN_BLOCK_LOG2 = 4
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic                                              mode_in,
  input  logic [15:0]                                       req_in,
  input  logic [31:0]                                       addr_in,
  input  logic [31:0]                                       heap_base,
  input  logic                                              out_free,
  output logic                                              in_ready,
  output logic                                              fin,
  output logic [31:0]                                       res_addr,
  output logic [1:0]                                        res_status,
  output bal_pkg::list_cmd_t                                lcmd,
  output logic [$clog2(HEAP_LOG2-MIN_BLOCK_LOG2+1)-1:0]     l_cls,
  output logic [HEAP_LOG2-MIN_BLOCK_LOG2-1:0]               l_slot,
  input  bal_pkg::list_rsp_t                                lrsp,
  input  logic [HEAP_LOG2-MIN_BLOCK_LOG2-1:0]               l_slot_out,
  output bal_pkg::tree_cmd_t                                tcmd,
  output logic [HEAP_LOG2-MIN_BLOCK_LOG2:0]                 t_node,
  input  bal_pkg::tree_rsp_t                                trsp
);
  import bal_pkg::*;

  localparam int SL     = HEAP_LOG2 - MIN_BLOCK_LOG2;
  localparam int NCLASS = SL + 1;
  localparam int CW     = $clog2(NCLASS);
  localparam int NW     = NCLASS;
  localparam int HB     = HEAP_LOG2;
  localparam int BW     = (HEAP_LOG2 + 1 > 17) ? HEAP_LOG2 + 1 : 17;
  localparam logic [BW-1:0] HEAP_BYTES = BW'(1) << HEAP_LOG2;
  localparam logic [CW-1:0] TOP_CLASS  = CW'(NCLASS - 1);

  typedef enum logic [22:0] {
    S_IDLE     = 23'd1 << 0,
    S_DISPATCH = 23'd1 << 1,
    S_INIT_CLR = 23'd1 << 2,
    S_INIT_ADD = 23'd1 << 3,
    S_A_LOOP   = 23'd1 << 4,
    S_A_TAKE   = 23'd1 << 5,
    S_A_TAKE2  = 23'd1 << 6,
    S_A_FOUND  = 23'd1 << 7,
    S_A_NFLIP  = 23'd1 << 8,
    S_A_SPLIT  = 23'd1 << 9,
    S_A_SFLIP  = 23'd1 << 10,
    S_A_SADD   = 23'd1 << 11,
    S_G_CHK    = 23'd1 << 12,
    S_G_BIT    = 23'd1 << 13,
    S_G_UNL    = 23'd1 << 14,
    S_G_ADDR   = 23'd1 << 15,
    S_G_CLR    = 23'd1 << 16,
    S_G_ADD0   = 23'd1 << 17,
    S_G_FLIP   = 23'd1 << 18,
    S_F_LOOP   = 23'd1 << 19,
    S_F_UNL    = 23'd1 << 20,
    S_F_ADD    = 23'd1 << 21,
    S_DONE     = 23'd1 << 22
  } ctrl_state_t;

  function automatic logic [CW-1:0] class_for(input logic [BW-1:0] b);
    int k;
    k = 0;
    for (int j = 0; j < NCLASS - 1; j++) begin
      if (b > (BW'(1) << (MIN_BLOCK_LOG2 + j))) k = j + 1;
    end
    return CW'(NCLASS - 1 - k);
  endfunction

  function automatic logic [NW-1:0] level_base(input logic [CW-1:0] c);
    return (NW'(1) << c) - NW'(1);
  endfunction

  function automatic logic [NW-1:0] node_of(input logic [HB-1:0] off,
                                            input logic [CW-1:0] c);
    return NW'(off >> (HB - c)) + level_base(c);
  endfunction

  function automatic logic [SL-1:0] slot_of(input logic [NW-1:0] nd,
                                            input logic [CW-1:0] c);
    logic [NW-1:0] d;
    d = nd - level_base(c);
    return SL'(d) << (SL - c);
  endfunction

  ctrl_state_t   state;
  logic          issued;
  logic          mode_q;
  logic [BW-1:0] bytes_q;
  logic [31:0]   addr_q;
  logic [CW-1:0] want, c, uc, lim, gc;
  logic [NW-1:0] node;
  logic [SL-1:0] slot_q;
  logic          heap_ready, ret_take2, gbit;
  logic          use_l, use_t, call_done;
  logic [CW-1:0] cf;
  logic [NW-1:0] root;
  logic [31:0]   off_full;
  logic [HB-1:0] heap_off;
  logic [HB-1:0] slot_off;

  assign cf        = class_for(bytes_q);
  assign root      = level_base(lim);
  assign off_full  = addr_q - 32'(HEADER_BYTES) - heap_base;
  assign heap_off  = off_full[HB-1:0];
  assign slot_off  = {slot_q, {MIN_BLOCK_LOG2{1'b0}}};
  assign call_done = issued && (lrsp.done || trsp.done);

  always_comb begin
    use_l   = 1'b0;
    use_t   = 1'b0;
    lcmd.op = L_ADD;
    l_cls   = lim;
    l_slot  = '0;
    tcmd.op = T_FLIP;
    t_node  = node;
    unique case (state)
      S_INIT_CLR: begin
        use_l = 1'b1; lcmd.op = L_CLEAR; l_cls = TOP_CLASS;
      end
      S_INIT_ADD: begin
        use_l = 1'b1; lcmd.op = L_ADD; l_cls = TOP_CLASS;
      end
      S_A_TAKE, S_A_TAKE2: begin
        use_l = 1'b1; lcmd.op = L_TAKE; l_cls = uc;
      end
      S_A_NFLIP, S_F_LOOP: use_t = (node != '0);
      S_A_SFLIP: use_t = 1'b1;
      S_A_SADD: begin
        use_l = 1'b1; l_cls = uc; l_slot = slot_of(node + NW'(1), uc);
      end
      S_G_BIT: begin
        use_t = 1'b1; tcmd.op = T_READ; t_node = root;
      end
      S_G_UNL: begin
        use_l = 1'b1; lcmd.op = L_UNLINK;
      end
      S_G_ADDR: begin
        use_l = 1'b1; l_slot = slot_of(root + NW'(1), lim);
      end
      S_G_CLR: begin
        use_l = 1'b1; lcmd.op = L_CLEAR;
      end
      S_G_ADD0: use_l = 1'b1;
      S_G_FLIP: begin
        use_t = (root != '0); t_node = root;
      end
      S_F_UNL: begin
        use_l = 1'b1; lcmd.op = L_UNLINK; l_cls = c;
        l_slot = slot_of(((node - NW'(1)) ^ NW'(1)) + NW'(1), c);
      end
      S_F_ADD: begin
        use_l = 1'b1; l_cls = c; l_slot = slot_of(node, c);
      end
      default: use_l = 1'b0;
    endcase
    lcmd.start = use_l && !issued;
    tcmd.start = use_t && !issued;
  end

  assign fin      = (state == S_DONE) && out_free;
  assign in_ready = (state == S_IDLE) && trsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      lim        <= TOP_CLASS;
      heap_ready <= 1'b0;
    end else begin
      if ((use_l || use_t) && !issued) begin
        issued <= 1'b1;
      end else if (call_done) begin
        issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_q  <= mode_in;
            bytes_q <= BW'(req_in) + BW'(HEADER_BYTES);
            addr_q  <= addr_in;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_addr   <= '0;
          res_status <= ST_OK;
          if (mode_q == MODE_ALLOC) begin
            if (bytes_q > HEAP_BYTES) begin
              res_status <= ST_FAIL;
              state      <= S_DONE;
            end else begin
              want <= cf;
              c    <= cf;
              if (!heap_ready) begin
                heap_ready <= 1'b1;
                lim        <= TOP_CLASS;
                state      <= S_INIT_CLR;
              end else begin
                state <= S_A_LOOP;
              end
            end
          end else if (addr_q == '0) begin
            res_status <= ST_NULL;
            state      <= S_DONE;
          end else if (!heap_ready || bytes_q > HEAP_BYTES) begin
            state <= S_DONE;
          end else begin
            c     <= cf;
            node  <= node_of(heap_off, cf);
            state <= S_F_LOOP;
          end
        end
        S_INIT_CLR: if (call_done) state <= S_INIT_ADD;
        S_INIT_ADD: if (call_done) state <= S_A_LOOP;
        S_A_LOOP: begin
          uc        <= c;
          gc        <= c;
          ret_take2 <= 1'b0;
          state     <= S_G_CHK;
        end
        S_G_CHK: begin
          if (gc < lim) begin
            state <= S_G_BIT;
          end else begin
            state <= ret_take2 ? S_A_TAKE2 : S_A_TAKE;
          end
        end
        S_G_BIT: begin
          if (call_done) begin
            gbit  <= trsp.value;
            state <= trsp.value ? S_G_ADDR : S_G_UNL;
          end
        end
        S_G_UNL, S_G_ADDR: begin
          if (call_done) begin
            lim   <= lim - CW'(1);
            state <= S_G_CLR;
          end
        end
        S_G_CLR: if (call_done) state <= gbit ? S_G_FLIP : S_G_ADD0;
        S_G_ADD0: if (call_done) state <= S_G_CHK;
        S_G_FLIP: if (!use_t || call_done) state <= S_G_CHK;
        S_A_TAKE: begin
          if (call_done) begin
            if (lrsp.ok) begin
              slot_q <= l_slot_out;
              state  <= S_A_FOUND;
            end else if (uc != lim || uc == '0) begin
              if (c == '0) begin
                res_status <= ST_FAIL;
                state      <= S_DONE;
              end else begin
                c     <= c - CW'(1);
                state <= S_A_LOOP;
              end
            end else begin
              gc        <= uc - CW'(1);
              ret_take2 <= 1'b1;
              state     <= S_G_CHK;
            end
          end
        end
        S_A_TAKE2: begin
          if (call_done) begin
            if (lrsp.ok) begin
              slot_q <= l_slot_out;
              state  <= S_A_FOUND;
            end else begin
              res_status <= ST_FAIL;
              state      <= S_DONE;
            end
          end
        end
        S_A_FOUND: begin
          node  <= node_of(slot_off, uc);
          state <= S_A_NFLIP;
        end
        S_A_NFLIP: if (!use_t || call_done) state <= S_A_SPLIT;
        S_A_SPLIT: begin
          if (uc < want) begin
            node  <= {node[NW-2:0], 1'b1};
            uc    <= uc + CW'(1);
            state <= S_A_SFLIP;
          end else begin
            res_addr <= heap_base + 32'(slot_off) + 32'(HEADER_BYTES);
            state    <= S_DONE;
          end
        end
        S_A_SFLIP: if (call_done) state <= S_A_SADD;
        S_A_SADD: if (call_done) state <= S_A_SPLIT;
        S_F_LOOP: begin
          if (!use_t) begin
            state <= S_F_ADD;
          end else if (call_done) begin
            state <= (trsp.value || c == lim) ? S_F_ADD : S_F_UNL;
          end
        end
        S_F_UNL: begin
          if (call_done) begin
            node  <= (node - NW'(1)) >> 1;
            c     <= c - CW'(1);
            state <= S_F_LOOP;
          end
        end
        S_F_ADD: if (call_done) state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `BAL_IMPLIES(a_rsp_needs_call, lrsp.done || trsp.done, issued, "unit response with no call")
  `BAL_IMPLIES(a_one_call, lcmd.start, !tcmd.start && !issued, "overlapping unit calls")
  `BAL_NEXT(a_fin_to_idle, fin, state == S_IDLE, "sequencer did not return to idle")
  `BAL_IMPLIES(a_lim_before_init, !heap_ready, lim == TOP_CLASS, "root grew before heap init")

endmodule

// ===== sv/buddy_allocator.sv =====
// Buddy allocator top level: config register, handshakes, result register
// Throughput: one item at a time; next item accepted the cycle after the result registers.
// Reset: synchronous; split bits are swept clear after reset, with in_ready low;
// config writes are taken throughout.
module buddy_allocator #(
  parameter int HEAP_LOG2      = 16,
  parameter int MIN_BLOCK_LOG2 = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] request_size,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_address,
  output logic [1:0]  status
);
  import bal_pkg::*;

  localparam int SL = HEAP_LOG2 - MIN_BLOCK_LOG2;
  localparam int CW = $clog2(SL + 1);

  logic [31:0]   heap_base;
  logic          fin;
  logic [31:0]   res_addr;
  logic [1:0]    res_status;
  list_cmd_t     lcmd;
  list_rsp_t     lrsp;
  tree_cmd_t     tcmd;
  tree_rsp_t     trsp;
  logic [CW-1:0] l_cls;
  logic [SL-1:0] l_slot, l_slot_out;
  logic [SL:0]   t_node;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= BASE_RESET;
    end else if (cfg_valid) begin
      heap_base <= cfg_data;
    end
  end

  bal_ctrl #(
    .HEAP_LOG2      (HEAP_LOG2),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .mode_in    (mode),
    .req_in     (request_size),
    .addr_in    (block_address),
    .heap_base  (heap_base),
    .out_free   (!out_valid || out_ready),
    .in_ready   (in_ready),
    .fin        (fin),
    .res_addr   (res_addr),
    .res_status (res_status),
    .lcmd       (lcmd),
    .l_cls      (l_cls),
    .l_slot     (l_slot),
    .lrsp       (lrsp),
    .l_slot_out (l_slot_out),
    .tcmd       (tcmd),
    .t_node     (t_node),
    .trsp       (trsp)
  );

  bal_list #(
    .SLOT_BITS (SL)
  ) u_list (
    .clk      (clk),
    .rst      (rst),
    .cmd      (lcmd),
    .cls      (l_cls),
    .slot     (l_slot),
    .rsp      (lrsp),
    .slot_out (l_slot_out)
  );

  bal_tree #(
    .SLOT_BITS (SL)
  ) u_tree (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tcmd),
    .node (t_node),
    .rsp  (trsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result_address <= res_addr;
      status         <= res_status;
    end
  end

endmodule
